// ----- rtl/batch_job_dispatcher_assert.svh -----
// Assertion macros for the batch job dispatcher.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef BATCH_JOB_DISPATCHER_ASSERT_SVH
`define BATCH_JOB_DISPATCHER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BJD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("batch job dispatcher assertion failed");
// Next-cycle implication, disabled during reset.
`define BJD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("batch job dispatcher assertion failed");
`else
`define BJD_ASSERT_IMP(label, clk, rst, ante, cons)
`define BJD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/bjd_pkg.sv -----
// Shared types, codes and sizes of the batch job dispatcher.
// No dependencies; every other RTL file but the assertion header imports this package.
`default_nettype none

package bjd_pkg;

  localparam int MAX_PROCS   = 32;
  localparam int STACK_DEPTH = 32;
  localparam int RANK_LIMIT  = (MAX_PROCS < STACK_DEPTH) ? MAX_PROCS : STACK_DEPTH;

  localparam int JOB_W  = 31;
  localparam int PROC_W = 6;
  localparam int WID_W  = 5;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int CMD_W  = 2;
  localparam int KIND_W = 2;
  localparam int ERR_W  = 2;
  localparam int IDX_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_START       = 2'd0,
    CMD_DONE        = 2'd1,
    CMD_RELEASE_ALL = 2'd2
  } cmd_code_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_JOB      = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_FINISHED = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE       = 2'd0,
    ERR_NO_WORKERS = 2'd1,
    ERR_STARTED    = 2'd2
  } err_code_t;

  typedef enum logic [IDX_W-1:0] {
    REG_JOB_COUNT     = 2'd0,
    REG_BATCH_LIMIT   = 2'd1,
    REG_PROCESS_COUNT = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERROR,
    S_FILL,
    S_RELEASE,
    S_ASSIGN,
    S_REL_ALL
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic      start_load;
    logic      err_set;
    err_code_t err_code;
    logic      done_push;
    logic      fill_push;
    logic      rel_all_load;
    logic      run_clear;
    logic      emit_release;
    logic      emit_assign;
    logic      emit_finish;
    logic      emit_error;
    logic      last;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic started;
    logic no_workers;
    logic done_ok;
    logic fill_more;
    logic rel_more;
    logic rel_last;
    logic have_work;
    logic assign_last;
    logic all_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/bjd_if.sv -----
// Handshake channels of the batch job dispatcher: requests, messages, config.
// Depends on bjd_pkg for field widths.
`default_nettype none

interface bjd_req_if import bjd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [WID_W-1:0] worker_id;

  modport source (output valid, command, worker_id, input ready);
  modport sink   (input valid, command, worker_id, output ready);
endinterface

interface bjd_msg_if import bjd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [WID_W-1:0]  dest_worker;
  logic [JOB_W-1:0]  job_first;
  logic [JOB_W-1:0]  job_end;
  logic [ERR_W-1:0]  error_code;
  logic              last;

  modport source (output valid, kind, dest_worker, job_first, job_end, error_code, last,
                  input ready);
  modport sink   (input valid, kind, dest_worker, job_first, job_end, error_code, last,
                  output ready);
endinterface

interface bjd_cfg_if import bjd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [JOB_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bjd_ctrl.sv -----
// Sequencer of the batch job dispatcher: decodes requests and steps the datapath.
// Depends on bjd_pkg and the request channel in bjd_if.
`default_nettype none

module bjd_ctrl import bjd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bjd_req_if.sink    req,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.err_code = ERR_NONE;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (req.command)
            CMD_START: begin
              if (stat.started) begin
                cmd.err_set  = 1'b1;
                cmd.err_code = ERR_STARTED;
                state_next   = S_ERROR;
              end else if (stat.no_workers) begin
                cmd.err_set  = 1'b1;
                cmd.err_code = ERR_NO_WORKERS;
                state_next   = S_ERROR;
              end else begin
                cmd.start_load = 1'b1;
                state_next     = S_FILL;
              end
            end
            CMD_DONE: begin
              if (stat.done_ok) begin
                cmd.done_push = 1'b1;
                state_next    = S_ASSIGN;
              end
            end
            CMD_RELEASE_ALL: begin
              if (stat.started) begin
                cmd.rel_all_load = 1'b1;
                state_next       = S_REL_ALL;
              end
            end
            default: ;
          endcase
        end
      end
      S_ERROR: begin
        if (stat.out_free) begin
          cmd.emit_error = 1'b1;
          cmd.last       = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_FILL: begin
        if (stat.fill_more) begin
          cmd.fill_push = 1'b1;
        end else begin
          state_next = S_RELEASE;
        end
      end
      // Releases at start are never the final word: assignments or the
      // finished word always follow them.
      S_RELEASE: begin
        if (stat.rel_more) begin
          if (stat.out_free) begin
            cmd.emit_release = 1'b1;
          end
        end else begin
          state_next = S_ASSIGN;
        end
      end
      S_ASSIGN: begin
        if (stat.have_work) begin
          if (stat.out_free) begin
            cmd.emit_assign = 1'b1;
            cmd.last        = stat.assign_last;
            if (stat.assign_last) begin
              state_next = S_IDLE;
            end
          end
        end else if (stat.all_done) begin
          if (stat.out_free) begin
            cmd.emit_finish = 1'b1;
            cmd.last        = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_REL_ALL: begin
        if (stat.rel_more) begin
          if (stat.out_free) begin
            cmd.emit_release = 1'b1;
            cmd.last         = stat.rel_last;
            if (stat.rel_last) begin
              cmd.run_clear = 1'b1;
              state_next    = S_IDLE;
            end
          end
        end else begin
          cmd.run_clear = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bjd_datapath.sv -----
// Datapath of the batch job dispatcher: config registers, idle-worker stack,
// job counters and the output word register. Depends on bjd_pkg, bjd_if and the assertion header.
`default_nettype none
`include "batch_job_dispatcher_assert.svh"

module bjd_datapath import bjd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  bjd_cfg_if.sink          cfg,
  input  logic [WID_W-1:0] worker_id,
  input  ctrl_cmd_t        cmd,
  output dp_stat_t         stat,
  bjd_msg_if.source        msg
);

  localparam int SUM_W = CNT_W + 1;

  // Configuration registers.
  logic [JOB_W-1:0]  job_count;
  logic [JOB_W-1:0]  batch_limit;
  logic [PROC_W-1:0] process_count;

  // Run state.
  logic [WID_W-1:0]  idle_stack [STACK_DEPTH];
  logic [CNT_W-1:0]  stack_count;
  logic [JOB_W-1:0]  next_job;
  logic [JOB_W-1:0]  jobs_left;
  logic [CNT_W-1:0]  busy_count;
  logic [JOB_W-1:0]  effective_split;
  logic              started;
  logic [PROC_W-1:0] idx;
  logic [PROC_W-1:0] active;
  err_code_t         err_code;

  logic [PROC_W-1:0] ranks;
  logic [PROC_W-1:0] workers;
  logic [PROC_W-1:0] active_calc;
  logic [JOB_W-1:0]  split_nz;
  logic [JOB_W-1:0]  split_calc;
  logic [JOB_W-1:0]  batch;
  logic [CNT_W-1:0]  stack_top;
  logic [WID_W-1:0]  top_worker;
  logic [SUM_W-1:0]  worker_sum;
  logic              out_free;
  logic              emit_any;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count     <= '0;
      batch_limit   <= JOB_W'(1);
      process_count <= PROC_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_JOB_COUNT:     job_count     <= cfg.data;
        REG_BATCH_LIMIT:   batch_limit   <= cfg.data;
        REG_PROCESS_COUNT: process_count <= cfg.data[PROC_W-1:0];
        default: ;
      endcase
    end
  end

  // Rank count is read live and capped at what the stack can hold.
  assign ranks   = (process_count > PROC_W'(RANK_LIMIT)) ? PROC_W'(RANK_LIMIT) : process_count;
  assign workers = ranks - PROC_W'(1);
  assign active_calc = (job_count < JOB_W'(workers)) ? job_count[PROC_W-1:0] : workers;

  // A zero batch limit, or a job count below the limit, falls back to single-job batches.
  assign split_nz   = (batch_limit == '0) ? JOB_W'(1) : batch_limit;
  assign split_calc = (job_count < split_nz) ? JOB_W'(1) : split_nz;

  assign batch      = (jobs_left < effective_split) ? jobs_left : effective_split;
  assign stack_top  = stack_count - CNT_W'(1);
  assign top_worker = idle_stack[stack_top[SP_W-1:0]];

  always_ff @(posedge clk) begin
    if (cmd.fill_push) begin
      idle_stack[stack_count[SP_W-1:0]] <= idx[WID_W-1:0];
    end else if (cmd.done_push) begin
      idle_stack[stack_count[SP_W-1:0]] <= worker_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count     <= '0;
      next_job        <= '0;
      jobs_left       <= '0;
      busy_count      <= '0;
      effective_split <= JOB_W'(1);
      started         <= 1'b0;
      idx             <= '0;
      active          <= '0;
    end else begin
      if (cmd.start_load) begin
        active          <= active_calc;
        idx             <= PROC_W'(1);
        stack_count     <= '0;
        effective_split <= split_calc;
        next_job        <= '0;
        jobs_left       <= job_count;
        busy_count      <= '0;
        started         <= 1'b1;
      end else if (cmd.fill_push) begin
        stack_count <= stack_count + CNT_W'(1);
        idx         <= idx + PROC_W'(1);
      end else if (cmd.done_push) begin
        stack_count <= stack_count + CNT_W'(1);
        busy_count  <= busy_count - CNT_W'(1);
      end else if (cmd.emit_assign) begin
        stack_count <= stack_top;
        next_job    <= next_job + batch;
        jobs_left   <= jobs_left - batch;
        busy_count  <= busy_count + CNT_W'(1);
      end else if (cmd.rel_all_load) begin
        idx <= PROC_W'(1);
      end else if (cmd.emit_release) begin
        idx <= idx + PROC_W'(1);
      end
      if (cmd.run_clear) begin
        stack_count <= '0;
        next_job    <= '0;
        jobs_left   <= '0;
        busy_count  <= '0;
        started     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.err_set) begin
      err_code <= cmd.err_code;
    end
  end

  // Output word register.
  assign out_free = !msg.valid || msg.ready;
  assign emit_any = cmd.emit_release || cmd.emit_assign || cmd.emit_finish || cmd.emit_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      msg.valid <= 1'b0;
    end else if (emit_any) begin
      msg.valid <= 1'b1;
    end else if (msg.ready) begin
      msg.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_any) begin
      msg.dest_worker <= '0;
      msg.job_first   <= '0;
      msg.job_end     <= '0;
      msg.error_code  <= ERR_NONE;
      msg.last        <= cmd.last;
      if (cmd.emit_assign) begin
        msg.kind        <= KIND_JOB;
        msg.dest_worker <= top_worker;
        msg.job_first   <= next_job;
        msg.job_end     <= next_job + batch;
      end else if (cmd.emit_release) begin
        msg.kind        <= KIND_RELEASE;
        msg.dest_worker <= idx[WID_W-1:0];
      end else if (cmd.emit_finish) begin
        msg.kind <= KIND_FINISHED;
      end else begin
        msg.kind       <= KIND_ERROR;
        msg.error_code <= err_code;
      end
    end
  end

  always_comb begin
    stat             = '0;
    stat.started     = started;
    stat.no_workers  = (ranks < PROC_W'(2));
    stat.done_ok     = started && (worker_id != '0) && ({1'b0, worker_id} < ranks)
                       && (busy_count != '0) && (stack_count < CNT_W'(STACK_DEPTH));
    stat.fill_more   = (idx <= active);
    stat.rel_more    = (idx < ranks);
    stat.rel_last    = (idx == workers);
    stat.have_work   = (jobs_left != '0) && (stack_count != '0);
    stat.assign_last = (jobs_left == batch) || (stack_count == CNT_W'(1));
    stat.all_done    = (jobs_left == '0) && (busy_count == '0);
    stat.out_free    = out_free;
  end

  assign worker_sum = SUM_W'(stack_count) + SUM_W'(busy_count);

  `BJD_ASSERT_IMP(a_not_started_empty, clk, rst, !started, (jobs_left == '0) && (busy_count == '0))
  `BJD_ASSERT_IMP(a_worker_bound, clk, rst, started, worker_sum < SUM_W'(STACK_DEPTH))
  `BJD_ASSERT_IMP(a_emit_slot, clk, rst, emit_any, out_free)
  `BJD_ASSERT_NEXT(a_batch_ok, clk, rst, cmd.emit_assign, msg.valid && msg.job_end > msg.job_first)

endmodule

`default_nettype wire

// ----- rtl/batch_job_dispatcher.sv -----
// Top level of the batch job dispatcher: sequencer plus datapath.
// Depends on bjd_pkg, bjd_if, bjd_ctrl and bjd_datapath.
//
//   channel  dir  word
//   req      in   command, worker_id
//   msg      out  kind, dest_worker, job_first, job_end, error_code, last
//   cfg      in   index, data (job count, batch limit, process count)
//
// One word leaves per cycle at most; a request is taken only when the sequencer
// is idle. A start fills the idle-worker stack, sends a release to each worker left
// without work, then hands out batches or sends the finished word. A done report
// pushes the worker and goes on to the assignment state, a start error sends one
// error word, release-all sends a release to every worker, and an ignored request
// sends nothing. A stalled output register holds the sequencer; the next request is taken
// while the final word of the previous one still waits. Reset is synchronous.
`default_nettype none

module batch_job_dispatcher import bjd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bjd_req_if.sink   req,
  bjd_msg_if.source msg,
  bjd_cfg_if.sink   cfg
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  bjd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat),
    .cmd  (cmd)
  );

  bjd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .worker_id (req.worker_id),
    .cmd       (cmd),
    .stat      (stat),
    .msg       (msg)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for batch_job_dispatcher: directed and random requests, each
// accepted request predicted in a scoreboard class and every outgoing word compared.
// Depends on bjd_pkg, bjd_if and the batch_job_dispatcher RTL.
`default_nettype none

module tb_top;
  import bjd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam logic [IDX_W-1:0] REG_UNUSED   = 2'd3;
  localparam logic [JOB_W-1:0] JOB_MAX      = '1;
  localparam logic [JOB_W-1:0] HALF_RANGE   = 31'h4000_0000;
  localparam int               ITEM_TARGET  = 330;
  localparam int               SETTLE_CYCLES = 2;
  localparam int               CYCLE_LIMIT  = 1_000_000;

  typedef struct {
    kind_t            kind;
    logic [WID_W-1:0] dest;
    logic [JOB_W-1:0] first;
    logic [JOB_W-1:0] job_end;
    err_code_t        err;
    logic             last;
  } dispatch_word_t;

  // Tracks the dispatcher state and the words each accepted request must produce.
  class dispatch_scoreboard;
    logic [JOB_W-1:0]  job_count_r = '0;
    logic [JOB_W-1:0]  split_r = 31'd1;
    logic [PROC_W-1:0] procs_r = 6'd1;
    logic [WID_W-1:0]  idle_stack[STACK_DEPTH];
    int unsigned       stack_cnt = 0;
    logic [JOB_W-1:0]  next_job = '0;
    logic [JOB_W-1:0]  jobs_left = '0;
    int unsigned       busy_cnt = 0;
    logic [JOB_W-1:0]  eff_split = 31'd1;
    bit                started = 1'b0;
    bit                acted;
    logic [WID_W-1:0]  busy_ids[$];
    dispatch_word_t    pending_msgs[$];
    int                errors = 0;
    int                n_batches = 0;
    int                n_releases = 0;
    int                n_finished = 0;
    int                n_error_words = 0;

    function void set_register(logic [IDX_W-1:0] idx, logic [JOB_W-1:0] data);
      case (idx)
        REG_JOB_COUNT:     job_count_r = data;
        REG_BATCH_LIMIT:   split_r = data;
        REG_PROCESS_COUNT: procs_r = data[PROC_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned rank_count();
      int unsigned r;
      r = procs_r;
      if (r > RANK_LIMIT) r = RANK_LIMIT;
      return r;
    endfunction

    function void push_word(kind_t k, int unsigned dest, logic [JOB_W-1:0] first,
                            logic [JOB_W-1:0] job_end, err_code_t e);
      dispatch_word_t w;
      w.kind = k;
      w.dest = dest[WID_W-1:0];
      w.first = first;
      w.job_end = job_end;
      w.err = e;
      w.last = 1'b0;
      pending_msgs.push_back(w);
    endfunction

    function void hand_out_batches();
      logic [JOB_W-1:0] batch;
      logic [WID_W-1:0] w;
      while (jobs_left != 0 && stack_cnt > 0) begin
        batch = (jobs_left < eff_split) ? jobs_left : eff_split;
        stack_cnt--;
        w = idle_stack[stack_cnt];
        push_word(KIND_JOB, w, next_job, next_job + batch, ERR_NONE);
        next_job = next_job + batch;
        jobs_left = jobs_left - batch;
        busy_cnt++;
        busy_ids.push_back(w);
      end
      if (jobs_left == 0 && busy_cnt == 0) push_word(KIND_FINISHED, 0, '0, '0, ERR_NONE);
    endfunction

    function void dispatch_request(logic [CMD_W-1:0] cmd, logic [WID_W-1:0] wid);
      int unsigned p, workers, active, prior_words, i;
      prior_words = pending_msgs.size();
      acted = 1'b1;
      p = rank_count();
      case (cmd)
        CMD_START: begin
          if (started) begin
            push_word(KIND_ERROR, 0, '0, '0, ERR_STARTED);
          end else if (p < 2) begin
            push_word(KIND_ERROR, 0, '0, '0, ERR_NO_WORKERS);
          end else begin
            workers = p - 1;
            active = (job_count_r < workers) ? job_count_r : workers;
            stack_cnt = 0;
            for (i = 1; i <= active; i++) begin
              idle_stack[stack_cnt] = i[WID_W-1:0];
              stack_cnt++;
            end
            for (i = active + 1; i < p; i++) push_word(KIND_RELEASE, i, '0, '0, ERR_NONE);
            eff_split = (split_r == 0) ? 31'd1 : split_r;
            if (job_count_r < eff_split) eff_split = 31'd1;
            next_job = '0;
            jobs_left = job_count_r;
            busy_cnt = 0;
            busy_ids.delete();
            started = 1'b1;
            hand_out_batches();
          end
        end
        CMD_DONE: begin
          if (started && wid != 0 && wid < p && busy_cnt > 0 && stack_cnt < STACK_DEPTH) begin
            busy_cnt--;
            for (i = 0; i < busy_ids.size(); i++) begin
              if (busy_ids[i] == wid) begin
                busy_ids.delete(i);
                break;
              end
            end
            idle_stack[stack_cnt] = wid;
            stack_cnt++;
            hand_out_batches();
          end else begin
            acted = 1'b0;
          end
        end
        CMD_RELEASE_ALL: begin
          if (started) begin
            for (i = 1; i < p; i++) push_word(KIND_RELEASE, i, '0, '0, ERR_NONE);
            stack_cnt = 0;
            next_job = '0;
            jobs_left = '0;
            busy_cnt = 0;
            busy_ids.delete();
            started = 1'b0;
          end else begin
            acted = 1'b0;
          end
        end
        default: acted = 1'b0;
      endcase
      if (pending_msgs.size() > prior_words) pending_msgs[pending_msgs.size()-1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [JOB_W-1:0] want, logic [JOB_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_message(logic [KIND_W-1:0] kind, logic [WID_W-1:0] dest,
                                logic [JOB_W-1:0] first, logic [JOB_W-1:0] job_end,
                                logic [ERR_W-1:0] err, logic last_w);
      dispatch_word_t want;
      if (pending_msgs.size() == 0) begin
        $error("unexpected word: kind %0d, dest_worker %0d", kind, dest);
        errors++;
        return;
      end
      want = pending_msgs.pop_front();
      compare_field("kind", want.kind, kind);
      compare_field("dest_worker", want.dest, dest);
      compare_field("job_first", want.first, first);
      compare_field("job_end", want.job_end, job_end);
      compare_field("error_code", want.err, err);
      compare_field("last", want.last, last_w);
      case (want.kind)
        KIND_JOB:      n_batches++;
        KIND_RELEASE:  n_releases++;
        KIND_FINISHED: n_finished++;
        default:       n_error_words++;
      endcase
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   quiet = 1'b0;
  int   counted = 0;
  int   ignored_count = 0;
  int   cycles = 0;
  dispatch_scoreboard sb;

  bjd_req_if req_ch ();
  bjd_msg_if msg_ch ();
  bjd_cfg_if cfg_ch ();

  batch_job_dispatcher DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .msg (msg_ch),
    .cfg (cfg_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && msg_ch.valid && msg_ch.ready) begin
      sb.check_message(msg_ch.kind, msg_ch.dest_worker, msg_ch.job_first, msg_ch.job_end,
                       msg_ch.error_code, msg_ch.last);
    end
  end

  // Receiver: ready stretches of random length, broken by stall bursts until quiet is set.
  initial begin
    msg_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      msg_ch.ready = 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if (!quiet && $urandom_range(0, 2) != 0) begin
        msg_ch.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
    end
  end

  task automatic pause_sender(int n);
    req_ch.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Valid stays high on return, unless a random pause drops it, so back-to-back requests wait on ready alone.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [WID_W-1:0] wid);
    req_ch.command = cmd;
    req_ch.worker_id = wid;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    sb.dispatch_request(cmd, wid);
    if (sb.acted) counted++;
    else ignored_count++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 11));
  endtask

  // Waits until every predicted word has arrived, then lets an ignored request finish.
  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (sb.pending_msgs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [IDX_W-1:0] idx, logic [JOB_W-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [WID_W-1:0] busy_worker();
    return sb.busy_ids[$urandom_range(0, sb.busy_ids.size() - 1)];
  endfunction

  function automatic logic [JOB_W-1:0] random_procs();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return $urandom_range(0, 1);
    if (roll < 25) return $urandom_range(20, 63);
    return $urandom_range(2, 9);
  endfunction

  function automatic logic [JOB_W-1:0] random_jobs();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return $urandom();
    if (roll < 21) return JOB_MAX;
    return $urandom_range(1, 40);
  endfunction

  function automatic logic [JOB_W-1:0] random_split();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return $urandom();
    return $urandom_range(1, 8);
  endfunction

  task automatic run_phase();
    int steps, limit_steps, roll;
    wait_idle();
    if ($urandom_range(0, 4) != 0) write_register(REG_PROCESS_COUNT, random_procs());
    if ($urandom_range(0, 3) != 0) write_register(REG_JOB_COUNT, random_jobs());
    if ($urandom_range(0, 3) != 0) write_register(REG_BATCH_LIMIT, random_split());
    if ($urandom_range(0, 15) == 0) write_register(REG_UNUSED, $urandom());
    if ($urandom_range(0, 9) == 0)
      send_request($urandom_range(1, 3), $urandom_range(0, 31));
    send_request(CMD_START, $urandom_range(0, 31));
    limit_steps = $urandom_range(4, 40);
    for (steps = 0; steps < limit_steps && sb.started; steps++) begin
      roll = $urandom_range(0, 99);
      if (sb.jobs_left == 0 && sb.busy_cnt == 0) begin
        // All finished: usually close the run, sometimes leave it open for the next start.
        if (roll < 70) send_request(CMD_RELEASE_ALL, $urandom_range(0, 31));
        else if (roll < 80) send_request(CMD_START, $urandom_range(0, 31));
        break;
      end else if (roll < 80 && sb.busy_ids.size() > 0) begin
        send_request(CMD_DONE, busy_worker());
      end else if (roll < 86) begin
        send_request(CMD_DONE, $urandom_range(0, 31));
      end else if (roll < 90) begin
        send_request(CMD_UNUSED, $urandom_range(0, 31));
      end else if (roll < 93) begin
        send_request(CMD_START, $urandom_range(0, 31));
      end else if (roll < 96) begin
        // The rank count is read live by done and release-all.
        wait_idle();
        write_register(REG_PROCESS_COUNT, $urandom_range(2, 12));
      end else begin
        send_request(CMD_RELEASE_ALL, $urandom_range(0, 31));
      end
    end
    if (sb.started && $urandom_range(0, 1) == 0) send_request(CMD_RELEASE_ALL, 0);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_START;
    req_ch.worker_id = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_JOB_COUNT;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Nothing started yet: done, release-all and the unused code are dropped, and the
    // reset rank count of one has no workers.
    send_request(CMD_DONE, 5'd3);
    send_request(CMD_RELEASE_ALL, '0);
    send_request(CMD_UNUSED, 5'd31);
    send_request(CMD_START, '0);
    wait_idle();
    write_register(REG_PROCESS_COUNT, '0);
    send_request(CMD_START, 5'd31);

    // No jobs with a zero split: every worker is released, then a second start.
    wait_idle();
    write_register(REG_PROCESS_COUNT, 31'd32);
    write_register(REG_JOB_COUNT, '0);
    write_register(REG_BATCH_LIMIT, '0);
    send_request(CMD_START, '0);
    send_request(CMD_START, '0);
    send_request(CMD_RELEASE_ALL, '0);

    // Full job range in two halves; the rank count saturates at the maximum.
    wait_idle();
    write_register(REG_PROCESS_COUNT, JOB_MAX);
    write_register(REG_JOB_COUNT, JOB_MAX);
    write_register(REG_BATCH_LIMIT, HALF_RANGE);
    send_request(CMD_START, '0);
    send_request(CMD_DONE, 5'd30);
    send_request(CMD_DONE, 5'd31);
    send_request(CMD_RELEASE_ALL, '0);

    // Split above the job count falls to one; bad worker ids and a done with nobody busy.
    wait_idle();
    write_register(REG_PROCESS_COUNT, 31'd6);
    write_register(REG_JOB_COUNT, 31'd3);
    write_register(REG_BATCH_LIMIT, JOB_MAX);
    send_request(CMD_START, '0);
    send_request(CMD_DONE, '0);
    send_request(CMD_DONE, 5'd31);
    repeat (3) send_request(CMD_DONE, busy_worker());
    send_request(CMD_DONE, 5'd2);
    send_request(CMD_RELEASE_ALL, '0);

    // Endless single-job batches, cut short by release-all.
    wait_idle();
    write_register(REG_JOB_COUNT, JOB_MAX);
    write_register(REG_BATCH_LIMIT, 31'd1);
    write_register(REG_PROCESS_COUNT, 31'd32);
    send_request(CMD_START, '0);
    send_request(CMD_DONE, busy_worker());
    send_request(CMD_RELEASE_ALL, '0);

    while (counted < ITEM_TARGET) begin
      if (counted >= ITEM_TARGET - 50) quiet = 1'b1;
      run_phase();
    end

    wait_idle();
    $display("Ran %0d effective and %0d ignored requests; checked %0d batches, %0d releases,",
             counted, ignored_count, sb.n_batches, sb.n_releases);
    $display("%0d finished words and %0d error words.", sb.n_finished, sb.n_error_words);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/bjd_pkg.sv
rtl/bjd_if.sv
rtl/bjd_ctrl.sv
rtl/bjd_datapath.sv
rtl/batch_job_dispatcher.sv
tb/tb_top.sv
